/* rtl/c3ced_pkg.sv */
package c3ced_pkg;
  localparam int MaxWidth = 2048;
  localparam int MaxHeight = 4096;
  localparam int ColW = $clog2(MaxWidth);
  localparam int RowW = $clog2(MaxHeight) + 1;
  localparam int CntW = ColW + RowW;

  typedef enum logic [2:0] {
    REG_K_TOP    = 3'd0,
    REG_K_MID    = 3'd1,
    REG_K_BOT    = 3'd2,
    REG_GRAY     = 3'd3,
    REG_EDGE     = 3'd4,
    REG_THRESH   = 3'd5,
    REG_WIDTH    = 3'd6,
    REG_HEIGHT   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [2:0][2:0][23:0] taps;
    logic                  row_end;
    logic                  frame_end;
  } job_t;

  function automatic logic [7:0] finish(input logic signed [33:0] s);
    logic signed [33:0] t;
    begin
      t = s >>> 12;
      if (s < 0) finish = 8'd0;
      else if (t > 34'sd255) finish = 8'd255;
      else finish = t[7:0];
    end
  endfunction
endpackage

/* rtl/c3ced_front.sv */
module c3ced_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             op_i,
  input  logic [23:0]      pix_i,
  input  logic [11:0]      width_cfg_i,
  input  logic [12:0]      height_cfg_i,
  output logic             job_valid_o,
  input  logic             job_ready_i,
  output c3ced_pkg::job_t  job_o
);
  import c3ced_pkg::*;

  typedef enum logic [1:0] {
    S_READ = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q;
  logic [23:0] near_mem [MaxWidth];
  logic [23:0] far_mem  [MaxWidth];
  logic [23:0] near_rd_q, far_rd_q;
  logic [2:0][2:0][23:0] win_q;
  logic [ColW:0] col_q, w_q;
  logic [RowW-1:0] row_q, h_q;
  logic [CntW-1:0] emit_q, n_q;
  logic [ColW:0] ocol_q;
  logic [RowW-1:0] orow_q;
  logic op_q;
  logic [23:0] pix_q;

  logic [ColW:0] w_l;
  logic [RowW-1:0] h_l;
  logic [ColW:0] w_eff;
  logic [RowW-1:0] h_eff;
  logic start, full, emits;
  logic [ColW-1:0] ci;
  logic [2:0][2:0][23:0] wn;
  job_t job;
  logic lastf;

  always_comb begin
    w_l = (width_cfg_i == 12'd0) ? (ColW+1)'(1) :
          (width_cfg_i > 12'(MaxWidth)) ? (ColW+1)'(MaxWidth) : width_cfg_i[ColW:0];
    h_l = (height_cfg_i == 13'd0) ? RowW'(1) :
          (height_cfg_i > 13'(MaxHeight)) ? RowW'(MaxHeight) : height_cfg_i[RowW-1:0];
  end

  assign start = !op_q && row_q == '0 && col_q == '0 && emit_q == '0;
  assign w_eff = start ? w_l : w_q;
  assign h_eff = start ? h_l : h_q;
  assign full = row_q >= h_eff;
  assign ci = col_q[ColW-1:0];
  assign emits = (n_q >= CntW'(w_eff) + CntW'(1)) && !(op_q && !full);
  assign lastf = (orow_q == h_eff - RowW'(1)) && (ocol_q == w_eff - (ColW+1)'(1));
  assign in_ready_o = (state_q == S_READ) && (!job_valid_o || job_ready_i);

  always_comb begin
    wn = win_q;
    if (!(op_q && !full)) begin
      for (int r = 0; r < 3; r++) begin
        wn[r][0] = win_q[r][1];
        wn[r][1] = win_q[r][2];
      end
      wn[0][2] = far_rd_q;
      wn[1][2] = near_rd_q;
      wn[2][2] = full ? 24'd0 : pix_q;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        int sr, sc;
        sr = r; sc = c;
        if (sr == 0 && orow_q == '0) sr = 1;
        if (sr == 2 && orow_q + RowW'(1) >= h_eff) sr = 1;
        if (sc == 0 && ocol_q == '0) sc = 1;
        if (sc == 2 && ocol_q + (ColW+1)'(1) >= w_eff) sc = 1;
        job.taps[r][c] = wn[sr][sc];
      end
    end
    job.row_end = ocol_q == w_eff - (ColW+1)'(1);
    job.frame_end = lastf;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      near_rd_q <= near_mem[ci];
      far_rd_q  <= far_mem[ci];
      pix_q     <= pix_i;
    end
    if (state_q == S_EXEC && !full && !op_q) begin
      far_mem[ci]  <= near_rd_q;
      near_mem[ci] <= pix_q;
    end
    if (state_q == S_EXEC && emits) job_o <= job;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_READ;
      win_q <= '0;
      col_q <= '0; row_q <= '0; emit_q <= '0; n_q <= '0;
      ocol_q <= '0; orow_q <= '0; op_q <= 1'b0;
      w_q <= (ColW+1)'(640); h_q <= RowW'(480);
      job_valid_o <= 1'b0;
    end else begin
      if (state_q == S_EXEC && emits) job_valid_o <= 1'b1;
      else if (job_ready_i) job_valid_o <= 1'b0;
      case (state_q)
        S_READ: begin
          if (in_valid_i && in_ready_o) begin
            op_q <= op_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_READ;
          w_q <= w_eff;
          h_q <= h_eff;
          if (!(op_q && !full)) begin
            win_q <= wn;
            if (emits && lastf) begin
              emit_q <= '0; row_q <= '0; col_q <= '0; n_q <= '0;
              ocol_q <= '0; orow_q <= '0;
            end else begin
              if (col_q + (ColW+1)'(1) >= w_eff) begin
                col_q <= '0;
                row_q <= row_q + RowW'(1);
              end else begin
                col_q <= col_q + (ColW+1)'(1);
              end
              n_q <= n_q + CntW'(1);
              if (emits) begin
                emit_q <= emit_q + CntW'(1);
                if (ocol_q + (ColW+1)'(1) >= w_eff) begin
                  ocol_q <= '0;
                  orow_q <= orow_q + RowW'(1);
                end else begin
                  ocol_q <= ocol_q + (ColW+1)'(1);
                end
              end
            end
          end
        end
        default: state_q <= S_READ;
      endcase
    end
  end
endmodule

/* rtl/c3ced_back.sv */
module c3ced_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  output logic             job_ready_o,
  input  c3ced_pkg::job_t  job_i,
  input  logic [2:0][47:0] kern_i,
  input  logic [47:0]      gray_i,
  input  logic             edge_i,
  input  logic [7:0]       thresh_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [25:0]      out_o
);
  import c3ced_pkg::*;

  // stage 1: grey, stage 2: products, stage 3: sum/clamp
  logic v1_q, v2_q;
  logic [2:0][2:0][3:0][7:0] ch1_q;
  logic [1:0] fl1_q, fl2_q;
  logic signed [2:0][2:0][3:0][24:0] pr_q;
  logic stall;

  assign stall = out_valid_o && !out_ready_i;
  assign job_ready_o = !stall;

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) begin
          logic [25:0] g;
          logic [9:0] gs;
          g = 26'(gray_i[47:32]) * 26'(job_i.taps[r][c][23:16]) +
              26'(gray_i[31:16]) * 26'(job_i.taps[r][c][15:8]) +
              26'(gray_i[15:0]) * 26'(job_i.taps[r][c][7:0]);
          gs = g[25:16];
          ch1_q[r][c][0] <= job_i.taps[r][c][23:16];
          ch1_q[r][c][1] <= job_i.taps[r][c][15:8];
          ch1_q[r][c][2] <= job_i.taps[r][c][7:0];
          ch1_q[r][c][3] <= (gs > 10'd255) ? 8'd255 : gs[7:0];
        end
      fl1_q <= {job_i.row_end, job_i.frame_end};
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          for (int k = 0; k < 4; k++)
            pr_q[r][c][k] <= $signed(kern_i[r][(2-c)*16 +: 16]) *
                             $signed({1'b0, ch1_q[r][c][k]});
      fl2_q <= fl1_q;
      for (int k = 0; k < 3; k++) begin
        logic signed [33:0] s;
        s = '0;
        for (int t = 0; t < 9; t++) s += 34'($signed(pr_q[t/3][t%3][edge_i ? 3 : k]));
        out_o[8*k +: 8] <= edge_i ? ((finish(s) >= thresh_i) ? 8'd255 : 8'd0) : finish(s);
      end
      out_o[25:24] <= fl2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; out_valid_o <= 1'b0;
    end else if (!stall) begin
      v1_q <= job_valid_i;
      v2_q <= v1_q;
      out_valid_o <= v2_q;
    end
  end
endmodule

/* rtl/conv3x3_clamp_edge_detect.sv */
// The result passes the front stage's job register, then the grey, product
// and sum/clamp registers of the filter pipeline.
// The front stage takes no new request until it has finished the line store
// read and write for the last one; output stalls hold the input. The output
// lags the input by one row plus one pixel.
// Reset: asynchronous active low; counters and window clear, registers take
// default values, line stores are not cleared.
module conv3x3_clamp_edge_detect (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // in_red, in_green, in_blue
  input  logic        s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // out_red, out_green, out_blue, row_end, frame_end
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i
);
  import c3ced_pkg::*;

  logic [2:0][47:0] kern_q;
  logic [47:0] gray_q;
  logic edge_q;
  logic [7:0] thr_q;
  logic [11:0] wid_q;
  logic [12:0] hgt_q;
  logic jv, jr;
  job_t job;
  logic [25:0] res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kern_q <= {48'd0, 48'd268435456, 48'd0};
      gray_q <= 48'd84162405342511;
      edge_q <= 1'b0; thr_q <= 8'd128; wid_q <= 12'd640; hgt_q <= 13'd480;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_K_TOP:  kern_q[0] <= cfg_data_i;
        REG_K_MID:  kern_q[1] <= cfg_data_i;
        REG_K_BOT:  kern_q[2] <= cfg_data_i;
        REG_GRAY:   gray_q <= cfg_data_i;
        REG_EDGE:   edge_q <= cfg_data_i[0];
        REG_THRESH: thr_q <= cfg_data_i[7:0];
        REG_WIDTH:  wid_q <= cfg_data_i[11:0];
        REG_HEIGHT: hgt_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  c3ced_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .op_i(s_axis_tuser),
    .pix_i({s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]}),
    .width_cfg_i(wid_q), .height_cfg_i(hgt_q),
    .job_valid_o(jv), .job_ready_i(jr), .job_o(job)
  );

  c3ced_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(jv), .job_ready_o(jr), .job_i(job),
    .kern_i(kern_q), .gray_i(gray_q), .edge_i(edge_q), .thresh_i(thr_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_o(res)
  );

  assign m_axis_tdata = {6'd0, res[24], res[25], res[23:16], res[15:8], res[7:0]} ;
endmodule

/* test/tb_conv3x3_clamp_edge_detect.sv */
`timescale 1ns / 100ps

module tb_conv3x3_clamp_edge_detect;
  import c3ced_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // in_red, in_green, in_blue
  logic        s_axis_tuser;   // op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // out_red, out_green, out_blue, row_end, frame_end
  logic        cfg_we_i;
  reg_idx_e    cfg_idx_i;
  logic [47:0] cfg_data_i;

  localparam bit OpPixel = 1'b0;
  localparam bit OpDrain = 1'b1;

  conv3x3_clamp_edge_detect DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  class conv_scoreboard;
    bit [23:0]   near_row[MaxWidth];
    bit [23:0]   far_row[MaxWidth];
    bit [23:0]   win[9];
    int unsigned col, row, emitted, cur_w, cur_h;
    bit [47:0]   krow[3];
    bit [47:0]   gray_w;
    bit          edge_on;
    bit [7:0]    thresh;
    bit [11:0]   width_reg;
    bit [12:0]   height_reg;
    bit [31:0]   pixel_q[$];
    int          errors;

    function void init();
      krow[0] = '0;
      krow[1] = 48'h0000_1000_0000;
      krow[2] = '0;
      gray_w = 48'd84162405342511;
      edge_on = 0;
      thresh = 8'd128;
      width_reg = 12'd640;
      height_reg = 13'd480;
      col = 0;
      row = 0;
      emitted = 0;
      foreach (win[i]) win[i] = '0;
      foreach (near_row[i]) begin
        near_row[i] = '0;
        far_row[i] = '0;
      end
      errors = 0;
      cur_w = eff_w();
      cur_h = eff_h();
    endfunction

    function int unsigned eff_w();
      if (width_reg == 0) return 1;
      return (width_reg > MaxWidth) ? MaxWidth : width_reg;
    endfunction

    function int unsigned eff_h();
      if (height_reg == 0) return 1;
      return (height_reg > MaxHeight) ? MaxHeight : height_reg;
    endfunction

    function bit at_frame_start();
      return row == 0 && col == 0 && emitted == 0;
    endfunction

    function void write_reg(reg_idx_e idx, bit [47:0] val);
      case (idx)
        REG_K_TOP:  krow[0] = val;
        REG_K_MID:  krow[1] = val;
        REG_K_BOT:  krow[2] = val;
        REG_GRAY:   gray_w = val;
        REG_EDGE:   edge_on = val[0];
        REG_THRESH: thresh = val[7:0];
        REG_WIDTH:  width_reg = val[11:0];
        REG_HEIGHT: height_reg = val[12:0];
        default: ;
      endcase
    endfunction

    function longint coef(int kr, int kc);
      bit signed [15:0] c;
      c = krow[kr][(32 - 16 * kc) +: 16];
      return c;
    endfunction

    function longint grey(bit [23:0] p);
      longint s;
      s = longint'(gray_w[47:32]) * p[23:16] + longint'(gray_w[31:16]) * p[15:8]
        + longint'(gray_w[15:0]) * p[7:0];
      s = s >> 16;
      return (s > 255) ? 255 : s;
    endfunction

    function bit [7:0] clamp_sum(longint s);
      if (s < 0) return 8'd0;
      s = s >>> 12;
      return (s > 255) ? 8'd255 : s[7:0];
    endfunction

    function void note(bit op, bit [23:0] pix);
      bit [23:0]   taps[9];
      bit [23:0]   colv[3];
      bit          full;
      int unsigned c, n, orow, ocol, sr, sc;
      longint      s;
      bit [7:0]    ch[3];
      bit          re, fe;
      if (op == OpPixel && at_frame_start()) begin
        cur_w = eff_w();
        cur_h = eff_h();
      end
      full = row >= cur_h;
      if (op == OpDrain && !full) return;
      c = col % MaxWidth;
      colv[0] = far_row[c];
      colv[1] = near_row[c];
      colv[2] = full ? 24'd0 : pix;
      for (int r = 0; r < 3; r++) begin
        win[r * 3] = win[r * 3 + 1];
        win[r * 3 + 1] = win[r * 3 + 2];
        win[r * 3 + 2] = colv[r];
      end
      if (!full) begin
        far_row[c] = near_row[c];
        near_row[c] = pix;
      end
      n = row * cur_w + col;
      col++;
      if (col >= cur_w) begin
        col = 0;
        row++;
      end
      if (n < cur_w + 1) return;
      orow = emitted / cur_w;
      ocol = emitted % cur_w;
      for (int k = 0; k < 9; k++) begin
        sr = k / 3;
        sc = k % 3;
        if (sr == 0 && orow == 0) sr = 1;
        if (sr == 2 && orow + 1 >= cur_h) sr = 1;
        if (sc == 0 && ocol == 0) sc = 1;
        if (sc == 2 && ocol + 1 >= cur_w) sc = 1;
        taps[k] = win[sr * 3 + sc];
      end
      if (edge_on) begin
        s = 0;
        for (int k = 0; k < 9; k++) s += coef(k / 3, k % 3) * grey(taps[k]);
        ch[0] = (clamp_sum(s) >= thresh) ? 8'd255 : 8'd0;
        ch[1] = ch[0];
        ch[2] = ch[0];
      end else begin
        for (int q = 0; q < 3; q++) begin
          s = 0;
          for (int k = 0; k < 9; k++)
            s += coef(k / 3, k % 3) * longint'(taps[k][(16 - 8 * q) +: 8]);
          ch[q] = clamp_sum(s);
        end
      end
      re = (ocol + 1 == cur_w);
      fe = (emitted + 1 == cur_w * cur_h);
      pixel_q.push_back({6'd0, fe, re, ch[2], ch[1], ch[0]});
      emitted++;
      if (fe) begin
        emitted = 0;
        row = 0;
        col = 0;
      end
    endfunction

    task report(string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check(bit [31:0] got);
      bit [31:0] want;
      if (pixel_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = pixel_q.pop_front();
      if (got[7:0] != want[7:0])
        report($sformatf("red %0d, want %0d", got[7:0], want[7:0]));
      if (got[15:8] != want[15:8])
        report($sformatf("green %0d, want %0d", got[15:8], want[15:8]));
      if (got[23:16] != want[23:16])
        report($sformatf("blue %0d, want %0d", got[23:16], want[23:16]));
      if (got[24] != want[24])
        report($sformatf("row_end %0b, want %0b", got[24], want[24]));
      if (got[25] != want[25])
        report($sformatf("frame_end %0b, want %0b", got[25], want[25]));
    endtask
  endclass

  conv_scoreboard sb;
  bit calm;
  int unsigned sent;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb_conv3x3_clamp_edge_detect: errors");
    $finish;
  end

  always @(negedge clk_i) begin
    if (!rst_ni || calm) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(99) >= 19);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);
  end

  task automatic send_item(bit op, bit [23:0] pix);
    if (!calm) begin
      while ($urandom_range(99) < 19) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {pix[7:0], pix[15:8], pix[23:16]};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note(op, pix);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pixel_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, bit [47:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic bit [23:0] rand_pixel();
    case ($urandom_range(7))
      0: return 24'h000000;
      1: return 24'hffffff;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic bit [47:0] rand_krow();
    bit [47:0] v;
    for (int i = 0; i < 3; i++)
      if ($urandom_range(1)) v[16 * i +: 16] = 16'($urandom);
      else v[16 * i +: 16] = 16'($urandom_range(8192) - 4096);
    return v;
  endfunction

  // noisy frames throw in drains mid-frame (ignored) and pixels after
  // the frame is complete (treated as drains)
  task automatic run_frame(bit noisy);
    int unsigned npix;
    npix = sb.eff_w() * sb.eff_h();
    for (int unsigned i = 0; i < npix; i++) begin
      if (noisy && $urandom_range(9) == 0) send_item(OpDrain, 24'($urandom));
      send_item(OpPixel, rand_pixel());
    end
    do begin
      if (noisy && $urandom_range(3) == 0) send_item(OpPixel, 24'($urandom));
      else send_item(OpDrain, 24'($urandom));
    end while (!sb.at_frame_start());
  endtask

  task automatic set_frame(bit [11:0] w, bit [12:0] h);
    write_reg(REG_WIDTH, 48'(w));
    write_reg(REG_HEIGHT, 48'(h));
  endtask

  initial begin
    sb = new();
    sb.init();
    calm = 0;
    sent = 0;
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = 0;
    m_axis_tready = 0;
    cfg_we_i = 0;
    cfg_idx_i = REG_K_TOP;
    cfg_data_i = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: identity kernel, small frame with extreme pixels
    set_frame(12'd4, 13'd3);
    send_item(OpDrain, 24'hffffff);
    send_item(OpPixel, 24'h000000);
    send_item(OpPixel, 24'hffffff);
    send_item(OpPixel, 24'hff0000);
    send_item(OpPixel, 24'h00ff00);
    send_item(OpDrain, 24'h0);
    send_item(OpPixel, 24'h0000ff);
    for (int i = 0; i < 7; i++) send_item(OpPixel, rand_pixel());
    send_item(OpPixel, 24'h123456);
    while (!sb.at_frame_start()) send_item(OpDrain, 24'h0);
    settle();

    // single pixel frames, zero geometry acts as one
    set_frame(12'd1, 13'd1);
    run_frame(1);
    settle();
    set_frame(12'd0, 13'd0);
    write_reg(REG_K_TOP, 48'h0000_f000_0000);
    write_reg(REG_K_BOT, 48'h1000_2000_1000);
    run_frame(0);
    settle();

    // edge mode: all-negative kernel, threshold extremes, overflowing grey weights
    write_reg(REG_K_TOP, 48'hffff_ffff_ffff);
    write_reg(REG_K_MID, 48'hffff_8000_ffff);
    write_reg(REG_K_BOT, 48'hffff_ffff_ffff);
    write_reg(REG_EDGE, 48'd1);
    write_reg(REG_THRESH, 48'd0);
    set_frame(12'd5, 13'd4);
    run_frame(1);
    settle();
    write_reg(REG_THRESH, 48'd255);
    write_reg(REG_GRAY, 48'hffff_ffff_ffff);
    write_reg(REG_K_MID, 48'h0000_1000_0000);
    run_frame(0);
    settle();
    write_reg(REG_K_MID, 48'h7fff_7fff_7fff);
    write_reg(REG_THRESH, 48'd128);
    write_reg(REG_GRAY, 48'd84162405342511);
    run_frame(1);
    settle();

    while (sent < 550) begin
      calm = ($urandom_range(4) == 0);
      write_reg(REG_K_TOP, rand_krow());
      write_reg(REG_K_MID, rand_krow());
      write_reg(REG_K_BOT, rand_krow());
      write_reg(REG_GRAY, 48'({$urandom, $urandom}));
      write_reg(REG_EDGE, 48'($urandom_range(1)));
      write_reg(REG_THRESH, 48'($urandom_range(255)));
      set_frame(12'($urandom_range(1, 8)), 13'($urandom_range(1, 6)));
      repeat ($urandom_range(1, 3)) run_frame($urandom_range(3) == 0);
      settle();
    end
    calm = 0;

    settle();
    if (sb.errors == 0) $display("tb_conv3x3_clamp_edge_detect: clean");
    else $display("tb_conv3x3_clamp_edge_detect: errors");
    $finish;
  end
endmodule

/* sim.f */
rtl/c3ced_pkg.sv
rtl/c3ced_front.sv
rtl/c3ced_back.sv
rtl/conv3x3_clamp_edge_detect.sv
test/tb_conv3x3_clamp_edge_detect.sv
